@@ sv/vgrt_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vgrt_pkg
// shared types, codes and sizes of the voxel grid ray traversal block
// ----------------------------------------------------------------------------
package vgrt_pkg;

  localparam int CHUNK_SIDE_DEF      = 16;
  localparam int CHUNKS_PER_AXIS_DEF = 4;

  localparam int CW          = 12;   // signed cell coordinate width during a walk
  localparam int OPW         = 3;
  localparam int DISTW       = 16;
  localparam int IN_TDATA_W  = 112;
  localparam int OUT_TDATA_W = 24;

  localparam logic [DISTW-1:0] MAX_DIST_RST = 16'd25600;
  localparam logic [31:0]      TSAT         = 32'hFFFF_FFFF;

  localparam logic [OPW-1:0] OP_ADD    = 3'd0;
  localparam logic [OPW-1:0] OP_REMOVE = 3'd1;
  localparam logic [OPW-1:0] OP_TOGGLE = 3'd2;
  localparam logic [OPW-1:0] OP_QUERY  = 3'd3;
  localparam logic [OPW-1:0] OP_RAY    = 3'd4;

  localparam logic [2:0] FACE_LEFT   = 3'd0;
  localparam logic [2:0] FACE_RIGHT  = 3'd1;
  localparam logic [2:0] FACE_BOTTOM = 3'd2;
  localparam logic [2:0] FACE_TOP    = 3'd3;
  localparam logic [2:0] FACE_FRONT  = 3'd4;
  localparam logic [2:0] FACE_BACK   = 3'd5;

  typedef enum logic {
    IU_SQRT = 1'b0,
    IU_DIV  = 1'b1
  } iu_op_t;

  typedef struct packed {
    logic   start;
    iu_op_t op;
  } iu_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } iu_sts_t;

  typedef struct packed {
    logic                 rd;
    logic                 wr;
    logic                 wbit;
    logic [2:0][CW-1:0]   coord;
  } mem_req_t;

  typedef struct packed {
    logic busy;
    logic in_grid;
    logic occ;
    logic chunk;
  } mem_rsp_t;

endpackage
`default_nettype wire

@@ sv/voxel_grid_ray_traversal.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// voxel_grid_ray_traversal
// voxel occupancy grid with edit, query and 3d dda ray cast
// ----------------------------------------------------------------------------
// One beat in, one beat out. After reset the grid is swept to zero, one row of
// (CHUNK_SIDE*CHUNKS_PER_AXIS) voxels a cycle, and in_tready stays low until
// all (CHUNK_SIDE*CHUNKS_PER_AXIS)^2 rows (4096 at the defaults) are clear. An
// edit or a query passes through the grid memory read-modify-write. A raycast
// finds the direction length by square root (2 bits a cycle), then per moving
// axis a division and the boundary multiply, then per visited voxel a memory
// read and a step, through the shared iterative unit and the single memory
// read port. The block takes one beat at a time. Configuration may be
// written only while the block is idle.
// ----------------------------------------------------------------------------
module voxel_grid_ray_traversal #(
  parameter int CHUNK_SIDE      = vgrt_pkg::CHUNK_SIDE_DEF,
  parameter int CHUNKS_PER_AXIS = vgrt_pkg::CHUNKS_PER_AXIS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // voxel_x, voxel_y, voxel_z, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
  input  logic [vgrt_pkg::IN_TDATA_W-1:0]  in_tdata,
  // operation
  input  logic [vgrt_pkg::OPW-1:0]         in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // hit_x, hit_y, hit_z, hit_face
  output logic [vgrt_pkg::OUT_TDATA_W-1:0] out_tdata,
  // success
  output logic                             out_tuser,
  input  logic                             cfg_wr_en,
  input  logic [vgrt_pkg::DISTW-1:0]       cfg_wr_data
);
  import vgrt_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE    = 12'b0000_0000_0001,
    S_ED_RD   = 12'b0000_0000_0010,
    S_ED_CHK  = 12'b0000_0000_0100,
    S_SQ_MUL  = 12'b0000_0000_1000,
    S_SQ_GO   = 12'b0000_0001_0000,
    S_SQ_WAIT = 12'b0000_0010_0000,
    S_DV_GO   = 12'b0000_0100_0000,
    S_DV_WAIT = 12'b0000_1000_0000,
    S_TM_MUL  = 12'b0001_0000_0000,
    S_WK_RD   = 12'b0010_0000_0000,
    S_WK_CHK  = 12'b0100_0000_0000,
    S_FIN     = 12'b1000_0000_0000
  } state_t;

  state_t             state_r, state_nxt;
  logic [DISTW-1:0]   max_r;
  logic               out_valid_r;

  logic [OPW-1:0]     op_r;
  logic [2:0][CW-1:0] cell_r;
  logic [7:0]         frac_r [3];
  logic [15:0]        dabs_r [3];
  logic [2:0]         dpos_r;
  logic [2:0]         dzero_r;
  logic [31:0]        sum_r;
  logic [15:0]        len_r;
  logic [31:0]        td_r [3];
  logic [31:0]        tm_r [3];
  logic [31:0]        t_r;
  logic [1:0]         axis_r;
  logic [2:0]         face_r;
  logic               first_r;
  logic               ok_r;
  logic [2:0][5:0]    hit_r;
  logic [2:0]         hface_r;
  logic               out_succ_r;
  logic [2:0][5:0]    out_hit_r;
  logic [2:0]         out_face_r;

  logic signed [5:0]  vox [3];
  logic signed [13:0] org [3];
  logic signed [15:0] dir [3];
  logic               in_acc;
  logic               out_ld;
  logic               last_axis;

  mem_req_t           mreq;
  mem_rsp_t           mrsp;
  iu_cmd_t            iu_cmd;
  iu_sts_t            iu_sts;
  logic [31:0]        iu_res;
  logic [31:0]        iu_opa;

  logic [15:0]        mul_a;
  logic [31:0]        mul_b;
  logic [47:0]        prod;
  logic [8:0]         bnd_dist;
  logic [31:0]        tm_prod;

  logic               ed_ok, ed_wr, ed_wbit;
  logic               t_lt;
  logic [1:0]         sel;
  logic [2:0]         dom_face;
  logic [31:0]        tm_sel;

  assign vox[0] = in_tdata[5:0];
  assign vox[1] = in_tdata[11:6];
  assign vox[2] = in_tdata[17:12];
  assign org[0] = in_tdata[31:18];
  assign org[1] = in_tdata[45:32];
  assign org[2] = in_tdata[59:46];
  assign dir[0] = in_tdata[75:60];
  assign dir[1] = in_tdata[91:76];
  assign dir[2] = in_tdata[107:92];

  assign in_tready = (state_r == S_IDLE) && !mrsp.busy;
  assign in_acc    = in_tvalid && in_tready;
  assign out_ld    = (state_r == S_FIN) && (!out_valid_r || out_tready);
  assign last_axis = (axis_r == 2'd2);

  vgrt_occ_mem #(
    .CHUNK_SIDE      (CHUNK_SIDE),
    .CHUNKS_PER_AXIS (CHUNKS_PER_AXIS)
  ) u_mem (
    .clk (clk),
    .rst_n (rst_n),
    .req (mreq),
    .rsp (mrsp)
  );

  vgrt_iter_unit u_iu (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (iu_cmd),
    .opa    (iu_opa),
    .opb    (dabs_r[axis_r]),
    .sts    (iu_sts),
    .result (iu_res)
  );

  // edit decode
  always_comb begin
    ed_ok   = 1'b0;
    ed_wr   = 1'b0;
    ed_wbit = 1'b0;
    unique case (op_r)
      OP_ADD: begin
        ed_ok   = mrsp.in_grid;
        ed_wr   = mrsp.in_grid;
        ed_wbit = 1'b1;
      end
      OP_REMOVE: begin
        ed_ok = mrsp.in_grid && mrsp.chunk;
        ed_wr = ed_ok;
      end
      OP_TOGGLE: begin
        if (mrsp.occ) begin
          ed_ok = mrsp.in_grid && mrsp.chunk;
          ed_wr = ed_ok;
        end else begin
          ed_ok   = mrsp.in_grid;
          ed_wr   = mrsp.in_grid;
          ed_wbit = 1'b1;
        end
      end
      OP_QUERY: ed_ok = mrsp.occ;
      default: ed_ok = 1'b0;
    endcase
  end

  always_comb begin
    mreq.rd    = (state_r == S_ED_RD) || (state_r == S_WK_RD);
    mreq.wr    = (state_r == S_ED_CHK) && ed_wr;
    mreq.wbit  = ed_wbit;
    mreq.coord = cell_r;
  end

  always_comb begin
    iu_cmd.start = (state_r == S_SQ_GO) || ((state_r == S_DV_GO) && !dzero_r[axis_r]);
    iu_cmd.op    = (state_r == S_SQ_GO) ? IU_SQRT : IU_DIV;
    iu_opa       = (state_r == S_SQ_GO) ? sum_r : {len_r, 16'b0};
  end

  // shared multiplier: squares, then distance to first boundary times tdelta
  always_comb begin
    if (dpos_r[axis_r]) begin
      bnd_dist = (frac_r[axis_r] == 8'd0) ? 9'd0 : (9'd256 - {1'b0, frac_r[axis_r]});
    end else begin
      bnd_dist = {1'b0, frac_r[axis_r]};
    end
    if (state_r == S_TM_MUL) begin
      mul_a = {7'b0, bnd_dist};
      mul_b = td_r[axis_r];
    end else begin
      mul_a = dabs_r[axis_r];
      mul_b = {16'b0, dabs_r[axis_r]};
    end
    prod    = mul_a * mul_b;
    tm_prod = (|prod[47:40]) ? TSAT : prod[39:8];
  end

  // walk decisions
  always_comb begin
    t_lt = t_r < {8'b0, max_r, 8'b0};
    if ((tm_r[0] < tm_r[1]) && (tm_r[0] < tm_r[2])) begin
      sel = 2'd0;
    end else if (tm_r[1] < tm_r[2]) begin
      sel = 2'd1;
    end else begin
      sel = 2'd2;
    end
    tm_sel = tm_r[2];
    for (int j = 0; j < 2; j++) begin
      if (sel == 2'(j)) begin
        tm_sel = tm_r[j];
      end
    end
    if ((dabs_r[0] > dabs_r[1]) && (dabs_r[0] > dabs_r[2])) begin
      dom_face = dpos_r[0] ? FACE_LEFT : FACE_RIGHT;
    end else if (dabs_r[1] > dabs_r[2]) begin
      dom_face = dpos_r[1] ? FACE_BOTTOM : FACE_TOP;
    end else begin
      dom_face = dpos_r[2] ? FACE_FRONT : FACE_BACK;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:    if (in_acc) state_nxt = (in_tuser == OP_RAY) ? S_SQ_MUL : S_ED_RD;
      S_ED_RD:   state_nxt = S_ED_CHK;
      S_ED_CHK:  state_nxt = S_FIN;
      S_SQ_MUL:  if (last_axis) state_nxt = S_SQ_GO;
      S_SQ_GO:   state_nxt = S_SQ_WAIT;
      S_SQ_WAIT: if (iu_sts.done) state_nxt = S_DV_GO;
      S_DV_GO: begin
        if (!dzero_r[axis_r]) begin
          state_nxt = S_DV_WAIT;
        end else if (last_axis) begin
          state_nxt = S_WK_RD;
        end
      end
      S_DV_WAIT: if (iu_sts.done) state_nxt = S_TM_MUL;
      S_TM_MUL:  state_nxt = last_axis ? S_WK_RD : S_DV_GO;
      S_WK_RD:   state_nxt = S_WK_CHK;
      S_WK_CHK:  state_nxt = (mrsp.occ || !t_lt) ? S_FIN : S_WK_RD;
      S_FIN:     if (out_ld) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      max_r       <= MAX_DIST_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        max_r <= cfg_wr_data;
      end
      out_valid_r <= out_ld || (out_valid_r && !out_tready);
    end
  end

  always_ff @(posedge clk) begin
    if (out_ld) begin
      out_succ_r <= ok_r;
      out_hit_r  <= hit_r;
      out_face_r <= hface_r;
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          op_r   <= in_tuser;
          sum_r  <= '0;
          axis_r <= 2'd0;
          for (int j = 0; j < 3; j++) begin
            if (in_tuser == OP_RAY) begin
              cell_r[j] <= {{(CW-6){org[j][13]}}, org[j][13:8]};
            end else begin
              cell_r[j] <= {{(CW-6){vox[j][5]}}, vox[j]};
            end
            frac_r[j]  <= org[j][7:0];
            dabs_r[j]  <= dir[j][15] ? 16'(-dir[j]) : dir[j];
            dpos_r[j]  <= !dir[j][15] && (dir[j] != 16'sd0);
            dzero_r[j] <= (dir[j] == 16'sd0);
          end
        end
      end
      S_ED_CHK: begin
        ok_r    <= ed_ok;
        hit_r   <= '0;
        hface_r <= FACE_LEFT;
      end
      S_SQ_MUL: begin
        sum_r  <= sum_r + prod[31:0];
        axis_r <= last_axis ? 2'd0 : axis_r + 2'd1;
      end
      S_SQ_WAIT: begin
        if (iu_sts.done) begin
          len_r <= iu_res[15:0];
        end
      end
      S_DV_GO: begin
        if (dzero_r[axis_r]) begin
          td_r[axis_r] <= TSAT;
          tm_r[axis_r] <= TSAT;
          axis_r       <= last_axis ? 2'd0 : axis_r + 2'd1;
          t_r          <= '0;
          first_r      <= 1'b1;
        end
      end
      S_DV_WAIT: begin
        if (iu_sts.done) begin
          td_r[axis_r] <= iu_res;
        end
      end
      S_TM_MUL: begin
        tm_r[axis_r] <= tm_prod;
        axis_r       <= last_axis ? 2'd0 : axis_r + 2'd1;
        t_r          <= '0;
        first_r      <= 1'b1;
      end
      S_WK_CHK: begin
        if (mrsp.occ) begin
          ok_r    <= 1'b1;
          hface_r <= first_r ? dom_face : face_r;
          for (int j = 0; j < 3; j++) begin
            hit_r[j] <= cell_r[j][5:0];
          end
        end else if (!t_lt) begin
          ok_r    <= 1'b0;
          hit_r   <= '0;
          hface_r <= FACE_LEFT;
        end else begin
          first_r <= 1'b0;
          t_r     <= tm_sel;
          for (int j = 0; j < 3; j++) begin
            if (sel == 2'(j)) begin
              if (dpos_r[j]) begin
                cell_r[j] <= cell_r[j] + CW'(1);
              end else if (!dzero_r[j]) begin
                cell_r[j] <= cell_r[j] - CW'(1);
              end
              tm_r[j] <= ({1'b0, tm_r[j]} + {1'b0, td_r[j]} > {1'b0, TSAT}) ? TSAT
                         : tm_r[j] + td_r[j];
              face_r  <= {sel, !dpos_r[j]};
            end
          end
        end
      end
      default: ;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_succ_r;
  assign out_tdata  = {3'b0, out_face_r, out_hit_r[2], out_hit_r[1], out_hit_r[0]};

endmodule
`default_nettype wire

@@ sv/vgrt_iter_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vgrt_iter_unit
// shared compare-subtract unit: integer square root (2 bits a cycle) and
// restoring division of a 32-bit dividend by a 16-bit divisor (1 bit a cycle)
// ----------------------------------------------------------------------------
module vgrt_iter_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  vgrt_pkg::iu_cmd_t cmd,
  input  logic [31:0]       opa,
  input  logic [15:0]       opb,
  output vgrt_pkg::iu_sts_t sts,
  output logic [31:0]       result
);
  import vgrt_pkg::*;

  logic        busy_r;
  logic        done_r;
  logic [4:0]  cnt_r;
  iu_op_t      op_r;
  logic [31:0] acc_r;
  logic [31:0] res_r;
  logic [31:0] bit_r;
  logic [15:0] rem_r;
  logic [15:0] dvs_r;
  logic [32:0] lhs;
  logic [32:0] rhs;
  logic [32:0] diff;
  logic        ge;

  always_comb begin
    if (op_r == IU_SQRT) begin
      lhs = {1'b0, acc_r};
      rhs = {1'b0, res_r + bit_r};
    end else begin
      lhs = {16'b0, rem_r, acc_r[31]};
      rhs = {17'b0, dvs_r};
    end
    diff = lhs - rhs;
    ge   = !diff[32];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (cmd.start) begin
        busy_r <= 1'b1;
        cnt_r  <= (cmd.op == IU_SQRT) ? 5'd15 : 5'd31;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 5'd1;
        if (cnt_r == 5'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op_r  <= cmd.op;
      acc_r <= opa;
      res_r <= '0;
      bit_r <= 32'h4000_0000;
      rem_r <= '0;
      dvs_r <= opb;
    end else if (busy_r) begin
      if (op_r == IU_SQRT) begin
        acc_r <= ge ? diff[31:0] : acc_r;
        res_r <= ge ? ((res_r >> 1) + bit_r) : (res_r >> 1);
        bit_r <= bit_r >> 2;
      end else begin
        rem_r <= ge ? diff[15:0] : lhs[15:0];
        acc_r <= {acc_r[30:0], 1'b0};
        res_r <= {res_r[30:0], ge};
      end
    end
  end

  assign sts    = '{busy: busy_r, done: done_r};
  assign result = res_r;

endmodule
`default_nettype wire

@@ sv/vgrt_occ_mem.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vgrt_occ_mem
// occupancy grid as one row of bits per (x, y) pair, chunk presence flags,
// registered read with read-modify-write, zero sweep after reset
// ----------------------------------------------------------------------------
module vgrt_occ_mem #(
  parameter int CHUNK_SIDE      = vgrt_pkg::CHUNK_SIDE_DEF,
  parameter int CHUNKS_PER_AXIS = vgrt_pkg::CHUNKS_PER_AXIS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  vgrt_pkg::mem_req_t req,
  output vgrt_pkg::mem_rsp_t rsp
);
  import vgrt_pkg::*;

  localparam int GSIDE = CHUNK_SIDE * CHUNKS_PER_AXIS;
  localparam int GOFFS = (CHUNKS_PER_AXIS / 2) * CHUNK_SIDE;
  localparam int ROWS  = GSIDE * GSIDE;
  localparam int GW    = $clog2(GSIDE);
  localparam int RAW   = $clog2(ROWS);
  localparam int NCH   = CHUNKS_PER_AXIS * CHUNKS_PER_AXIS * CHUNKS_PER_AXIS;
  localparam int CXW   = (CHUNKS_PER_AXIS > 1) ? $clog2(CHUNKS_PER_AXIS) : 1;
  localparam int CIW   = (NCH > 1) ? $clog2(NCH) : 1;

  logic [GSIDE-1:0] mem [ROWS];

  logic signed [CW:0] g [3];
  logic [GW-1:0]      gu [3];
  logic [2:0]         in_ax;
  logic [CXW-1:0]     cnt [3];
  logic               in_all;
  logic [RAW-1:0]     row_addr;
  logic [CIW-1:0]     chunk_idx;
  logic [GSIDE-1:0]   row_wr;

  logic               clr_r;
  logic [RAW-1:0]     clr_cnt_r;
  logic [NCH-1:0]     chunk_vec_r;
  logic [GSIDE-1:0]   row_q_r;
  logic [GW-1:0]      gz_q_r;
  logic               in_q_r;
  logic               chk_q_r;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      g[j]     = $signed({req.coord[j][CW-1], req.coord[j]}) + $signed((CW+1)'(GOFFS));
      in_ax[j] = !g[j][CW] && (g[j] < GSIDE);
      gu[j]    = g[j][GW-1:0];
      cnt[j]   = '0;
      for (int k = 1; k < CHUNKS_PER_AXIS; k++) begin
        if (int'(gu[j]) >= k * CHUNK_SIDE) begin
          cnt[j] = cnt[j] + CXW'(1);
        end
      end
    end
    in_all    = &in_ax;
    row_addr  = RAW'(int'(gu[0]) * GSIDE + int'(gu[1]));
    chunk_idx = CIW'((int'(cnt[0]) * CHUNKS_PER_AXIS + int'(cnt[1])) * CHUNKS_PER_AXIS
                     + int'(cnt[2]));
    row_wr         = row_q_r;
    row_wr[gu[2]]  = req.wbit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r       <= 1'b1;
      clr_cnt_r   <= '0;
      chunk_vec_r <= '0;
    end else begin
      if (clr_r) begin
        clr_cnt_r <= clr_cnt_r + RAW'(1);
        if (clr_cnt_r == RAW'(ROWS - 1)) begin
          clr_r <= 1'b0;
        end
      end
      if (req.wr && req.wbit && in_all) begin
        chunk_vec_r[chunk_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clr_r) begin
      mem[clr_cnt_r] <= '0;
    end else if (req.wr && in_all) begin
      mem[row_addr] <= row_wr;
    end
    if (req.rd) begin
      row_q_r <= mem[row_addr];
      gz_q_r  <= gu[2];
      in_q_r  <= in_all;
      chk_q_r <= chunk_vec_r[chunk_idx];
    end
  end

  assign rsp = '{busy: clr_r, in_grid: in_q_r, occ: in_q_r & row_q_r[gz_q_r],
                 chunk: chk_q_r};

endmodule
`default_nettype wire

@@ sv/vgrt_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vgrt_checker
// port-level checks of the voxel grid ray traversal block
// ----------------------------------------------------------------------------
module vgrt_checker (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             in_tvalid,
  input wire logic                             in_tready,
  input wire logic                             out_tvalid,
  input wire logic                             out_tready,
  input wire logic [vgrt_pkg::OUT_TDATA_W-1:0] out_tdata,
  input wire logic                             out_tuser
);
  import vgrt_pkg::*;

  // result beat holds while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed while stalled");

  // one item at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while an item is in work");

  // failed items carry all-zero fields
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == '0)
    else $error("failed result with nonzero fields");

  a_face_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[20:18] <= FACE_BACK)
    else $error("face code out of range");

endmodule

bind voxel_grid_ray_traversal vgrt_checker u_vgrt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the voxel grid ray traversal block: voxel edits,
// queries, unused opcodes and ray casts are streamed in with random idling on
// both sides, and every result beat is checked against a predictor with its
// own copy of the grid, chunk marks and ray length limit
// ----------------------------------------------------------------------------
module testbench;
  import vgrt_pkg::*;

  localparam int SIDE   = 64;
  localparam int OFFS   = 32;
  localparam int CSIDE  = 16;
  localparam int CAXIS  = 4;
  localparam int LIMIT  = 20000000;
  localparam logic [OPW-1:0] OP_SPARE5 = 3'd5;
  localparam logic [OPW-1:0] OP_SPARE6 = 3'd6;
  localparam logic [OPW-1:0] OP_SPARE7 = 3'd7;

  typedef struct {
    logic [OPW-1:0]     op;
    logic signed [5:0]  vx, vy, vz;
    logic signed [13:0] ox, oy, oz;
    logic signed [15:0] dx, dy, dz;
  } voxel_cmd_t;

  typedef struct {
    logic       ok;
    logic [5:0] hx, hy, hz;
    logic [2:0] face;
  } voxel_res_t;

  logic clk, rst_n;
  logic in_tvalid, in_tready, out_tvalid, out_tready, out_tuser;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [OPW-1:0]         in_tuser;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_wr_en;
  logic [DISTW-1:0]       cfg_wr_data;

  voxel_grid_ray_traversal i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  // predictor state
  bit occ_grid [0:SIDE*SIDE*SIDE-1];
  bit chunk_made [0:CAXIS*CAXIS*CAXIS-1];
  logic [DISTW-1:0] ray_limit;

  voxel_cmd_t cmd_queue[$];
  voxel_res_t expected_res[$];
  voxel_cmd_t target_pool[$];

  int  error_count, beats_in, beats_out, rays_cast, rays_hit, cycle_count;
  bit  in_taken, quiet, hold_off;
  int  in_gap, out_gap;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic bit in_grid(int x, int y, int z);
    return x + OFFS >= 0 && x + OFFS < SIDE && y + OFFS >= 0 && y + OFFS < SIDE &&
           z + OFFS >= 0 && z + OFFS < SIDE;
  endfunction

  function automatic int cell_idx(int x, int y, int z);
    return ((x + OFFS) * SIDE + (y + OFFS)) * SIDE + (z + OFFS);
  endfunction

  function automatic int chunk_idx(int x, int y, int z);
    return (((x + OFFS) / CSIDE) * CAXIS + (y + OFFS) / CSIDE) * CAXIS + (z + OFFS) / CSIDE;
  endfunction

  function automatic bit is_occ(int x, int y, int z);
    if (!in_grid(x, y, z)) return 1'b0;
    return occ_grid[cell_idx(x, y, z)];
  endfunction

  function automatic bit grid_add(int x, int y, int z);
    if (!in_grid(x, y, z)) return 1'b0;
    chunk_made[chunk_idx(x, y, z)] = 1'b1;
    occ_grid[cell_idx(x, y, z)] = 1'b1;
    return 1'b1;
  endfunction

  function automatic bit grid_remove(int x, int y, int z);
    if (!in_grid(x, y, z) || !chunk_made[chunk_idx(x, y, z)]) return 1'b0;
    occ_grid[cell_idx(x, y, z)] = 1'b0;
    return 1'b1;
  endfunction

  function automatic logic [31:0] int_sqrt(logic [31:0] v);
    logic [31:0] r, b;
    r = 0;
    b = 32'h4000_0000;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic voxel_res_t trace_ray(voxel_cmd_t c);
    voxel_res_t  r;
    int          o[3], d[3], cl[3], st[3], f, i, a0, a1, a2;
    logic [31:0] tm[3], td[3], t, lim, len, ad, bnd;
    logic [63:0] q;
    longint      sq;
    logic [32:0] s;
    r = '{1'b0, 6'd0, 6'd0, 6'd0, 3'd0};
    o[0] = c.ox; o[1] = c.oy; o[2] = c.oz;
    d[0] = c.dx; d[1] = c.dy; d[2] = c.dz;
    sq = longint'(d[0]) * d[0] + longint'(d[1]) * d[1] + longint'(d[2]) * d[2];
    len = int_sqrt(sq[31:0]);
    for (i = 0; i < 3; i++) begin
      f = o[i] & 255;
      cl[i] = o[i] >>> 8;
      if (d[i] == 0) begin
        st[i] = 0;
        tm[i] = TSAT;
        td[i] = TSAT;
      end else begin
        st[i] = d[i] > 0 ? 1 : -1;
        ad = d[i] > 0 ? d[i] : -d[i];
        q = ({32'd0, len} << 16) / {32'd0, ad};
        td[i] = q > {32'd0, TSAT} ? TSAT : q[31:0];
        if (d[i] > 0) bnd = (f == 0) ? 0 : 256 - f;
        else bnd = f;
        q = ({32'd0, bnd} * {32'd0, td[i]}) >> 8;
        tm[i] = q > {32'd0, TSAT} ? TSAT : q[31:0];
      end
    end
    if (is_occ(cl[0], cl[1], cl[2])) begin
      a0 = d[0] < 0 ? -d[0] : d[0];
      a1 = d[1] < 0 ? -d[1] : d[1];
      a2 = d[2] < 0 ? -d[2] : d[2];
      if (a0 > a1 && a0 > a2) r.face = d[0] > 0 ? FACE_LEFT : FACE_RIGHT;
      else if (a1 > a2) r.face = d[1] > 0 ? FACE_BOTTOM : FACE_TOP;
      else r.face = d[2] > 0 ? FACE_FRONT : FACE_BACK;
      r.ok = 1'b1;
      r.hx = cl[0][5:0]; r.hy = cl[1][5:0]; r.hz = cl[2][5:0];
      return r;
    end
    lim = {8'd0, ray_limit, 8'd0};
    t = 0;
    while (t < lim) begin
      if (tm[0] < tm[1] && tm[0] < tm[2]) i = 0;
      else if (tm[1] < tm[2]) i = 1;
      else i = 2;
      t = tm[i];
      cl[i] = cl[i] + st[i];
      s = {1'b0, tm[i]} + {1'b0, td[i]};
      tm[i] = s[32] ? TSAT : s[31:0];
      if (is_occ(cl[0], cl[1], cl[2])) begin
        r.ok = 1'b1;
        r.face = 3'(2 * i + (st[i] > 0 ? 0 : 1));
        r.hx = cl[0][5:0]; r.hy = cl[1][5:0]; r.hz = cl[2][5:0];
        return r;
      end
    end
    return r;
  endfunction

  function automatic voxel_res_t predict_result(voxel_cmd_t c);
    voxel_res_t r;
    r = '{1'b0, 6'd0, 6'd0, 6'd0, 3'd0};
    case (c.op)
      OP_ADD:    r.ok = grid_add(c.vx, c.vy, c.vz);
      OP_REMOVE: r.ok = grid_remove(c.vx, c.vy, c.vz);
      OP_TOGGLE: r.ok = is_occ(c.vx, c.vy, c.vz) ? grid_remove(c.vx, c.vy, c.vz)
                                                 : grid_add(c.vx, c.vy, c.vz);
      OP_QUERY:  r.ok = is_occ(c.vx, c.vy, c.vz);
      OP_RAY:    r = trace_ray(c);
      default:   ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string field, int got, int want);
    $display("beat %0d: %s got %0d expected %0d", beats_out, field, got, want);
    error_count++;
  endtask

  // input acceptance, prediction and result checking
  always @(posedge clk) begin
    voxel_cmd_t c;
    voxel_res_t e;
    cycle_count++;
    if (rst_n && in_tvalid && in_tready) begin
      c.op = in_tuser;
      {c.dz, c.dy, c.dx, c.oz, c.oy, c.ox, c.vz, c.vy, c.vx} = in_tdata[107:0];
      e = predict_result(c);
      if (c.op == OP_RAY) begin
        rays_cast++;
        if (e.ok) rays_hit++;
      end
      expected_res.push_back(e);
      beats_in++;
      in_taken = 1'b1;
    end
    if (rst_n && out_tvalid && out_tready) begin
      beats_out++;
      if (expected_res.size() == 0) begin
        $display("beat %0d: result with nothing expected", beats_out);
        error_count++;
      end else begin
        e = expected_res.pop_front();
        if (out_tuser !== e.ok) report_mismatch("success", out_tuser, e.ok);
        if (out_tdata[5:0] !== e.hx) report_mismatch("hit_x", out_tdata[5:0], e.hx);
        if (out_tdata[11:6] !== e.hy) report_mismatch("hit_y", out_tdata[11:6], e.hy);
        if (out_tdata[17:12] !== e.hz) report_mismatch("hit_z", out_tdata[17:12], e.hz);
        if (out_tdata[20:18] !== e.face) report_mismatch("hit_face", out_tdata[20:18], e.face);
      end
    end
  end

  always @(posedge clk) begin
    if (cycle_count > LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Mismatches found");
      $finish;
    end
  end

  // input driver
  always @(negedge clk) begin
    voxel_cmd_t c;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_tvalid && !in_taken) begin
      in_tvalid <= 1'b1;
    end else begin
      in_taken = 1'b0;
      if (in_gap > 0) begin
        in_gap--;
        in_tvalid <= 1'b0;
      end else if (cmd_queue.size() == 0 || hold_off) begin
        in_tvalid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        in_gap = $urandom_range(0, 9);
        in_tvalid <= 1'b0;
      end else begin
        c = cmd_queue.pop_front();
        in_tuser <= c.op;
        in_tdata <= {4'd0, c.dz, c.dy, c.dx, c.oz, c.oy, c.ox, c.vz, c.vy, c.vx};
        in_tvalid <= 1'b1;
      end
    end
  end

  // result stall driver
  always @(negedge clk) begin
    if (out_gap > 0) begin
      out_gap--;
      out_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      out_gap = $urandom_range(0, 9);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic push_voxel(logic [OPW-1:0] op, int x, int y, int z);
    voxel_cmd_t c;
    c = '{op, x, y, z, 0, 0, 0, 0, 0, 0};
    c.ox = $urandom; c.oy = $urandom; c.oz = $urandom;
    c.dx = $urandom; c.dy = $urandom; c.dz = $urandom;
    cmd_queue.push_back(c);
    if (op == OP_ADD) target_pool.push_back(c);
  endtask

  task automatic push_ray(int ox, int oy, int oz, int dx, int dy, int dz);
    voxel_cmd_t c;
    c = '{OP_RAY, 0, 0, 0, ox, oy, oz, dx, dy, dz};
    c.vx = $urandom; c.vy = $urandom; c.vz = $urandom;
    cmd_queue.push_back(c);
  endtask

  function automatic int near_coord();
    return $urandom_range(0, 3) == 0 ? $signed(6'($urandom)) : $urandom_range(0, 12) - 6;
  endfunction

  function automatic int pick_origin();
    return $urandom_range(0, 4) == 0 ? $signed(14'($urandom))
                                     : int'($urandom_range(0, 6144)) - 3072;
  endfunction

  task automatic push_random();
    voxel_cmd_t tg;
    int sel, ox, oy, oz, k;
    sel = $urandom_range(0, 99);
    if (sel < 34) push_voxel(OP_ADD, near_coord(), near_coord(), near_coord());
    else if (sel < 44) push_voxel(OP_REMOVE, near_coord(), near_coord(), near_coord());
    else if (sel < 54) push_voxel(OP_TOGGLE, near_coord(), near_coord(), near_coord());
    else if (sel < 68) push_voxel(OP_QUERY, near_coord(), near_coord(), near_coord());
    else if (sel < 71) push_voxel(3'($urandom_range(5, 7)), near_coord(), near_coord(),
                                  near_coord());
    else begin
      ox = pick_origin(); oy = pick_origin(); oz = pick_origin();
      if (target_pool.size() > 0 && $urandom_range(0, 2) != 0) begin
        // aim at the center of a voxel added earlier, at times with dx zeroed
        tg = target_pool[$urandom_range(0, target_pool.size() - 1)];
        k = $urandom_range(0, 3) == 0 ? 0 : 1;
        push_ray(ox, oy, oz, (tg.vx * 256 + 128 - ox) * k + (k == 0 ? 0 : 0),
                 (tg.vy * 256 + 128 - oy), (tg.vz * 256 + 128 - oz));
      end else if ($urandom_range(0, 1) == 0) begin
        push_ray(ox, oy, oz, $signed(16'($urandom)), $signed(16'($urandom)),
                 $signed(16'($urandom)));
      end else begin
        push_ray(ox & ~255, oy, oz, int'($urandom_range(0, 8)) - 4,
                 int'($urandom_range(0, 8)) - 4, int'($urandom_range(0, 8)) - 4);
      end
    end
  endtask

  task automatic wait_idle();
    while (cmd_queue.size() != 0 || in_tvalid || expected_res.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_limit(logic [DISTW-1:0] v);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    ray_limit = v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic run_phase(logic [DISTW-1:0] lim, int n);
    wait_idle();
    hold_off = 1'b1;
    write_limit(lim);
    repeat (n) push_random();
    hold_off = 1'b0;
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    out_tready = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    ray_limit = MAX_DIST_RST;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // directed part at the reset limit
    push_voxel(OP_REMOVE, 5, 5, 5);
    push_voxel(OP_QUERY, -32, -32, -32);
    push_voxel(OP_ADD, -32, -32, -32);
    push_voxel(OP_ADD, 31, 31, 31);
    push_voxel(OP_QUERY, 31, 31, 31);
    push_voxel(OP_REMOVE, 30, 31, 31);
    push_voxel(OP_TOGGLE, 31, 31, 31);
    push_voxel(OP_TOGGLE, 0, 0, 0);
    push_voxel(OP_SPARE5, 1, 2, 3);
    push_voxel(OP_SPARE6, -1, -2, -3);
    push_voxel(OP_SPARE7, 0, 0, 0);
    push_ray(0, 0, 0, 0, 0, 0);
    push_ray(128, 128, 128, 0, 0, 0);
    push_ray(100, 50, 20, 5, -3, 1);
    push_ray(100, 50, 20, -1, 6, 2);
    push_ray(100, 50, 20, 1, 1, -1);
    push_ray(-2560, 0, 0, 32767, 0, 0);
    push_ray(2560, 40, 90, -32768, 0, 0);
    push_ray(0, -2560, 0, 3, 32767, -2);
    push_ray(0, 0, 2560, 0, 0, -32768);
    push_ray(-8192, -8192, -8192, 32767, 32767, 32767);
    push_ray(8191, 8191, 8191, -32768, -32768, -32768);
    push_ray(-8192, 8191, 0, 32767, -32768, 1);
    push_voxel(OP_ADD, -32, 31, -32);
    push_ray(-8192, 8191, -8192, -1, 1, 0);

    run_phase(16'hFFFF, 220);
    run_phase(16'd0, 200);
    run_phase(16'd1, 200);
    run_phase(16'd2000, 350);
    wait_idle();
    quiet = 1'b1;
    run_phase(MAX_DIST_RST, 560);
    wait_idle();
    repeat (50) @(posedge clk);

    $display("%0d beats in, %0d results checked over 6 limit settings", beats_in, beats_out);
    $display("%0d rays cast, %0d of them hit a voxel", rays_cast, rays_hit);
    if (error_count == 0 && expected_res.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d mismatches, %0d results missing", error_count, expected_res.size());
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
